// File: hdl/hsvrgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types and constants shared by the HSV to RGB pixel core, its datapath and
// its checker.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int unsigned HUE_BITS     = 16;
	localparam int unsigned CHANNEL_BITS = 8;

	// Largest channel code, which stands for 1.0.
	localparam int unsigned FULL   = (1 << CHANNEL_BITS) - 1;
	localparam int unsigned DIST_W = HUE_BITS + 1;
	localparam int unsigned PROD_W = 2 * CHANNEL_BITS;
	localparam int unsigned Y_W    = PROD_W + DIST_W;

	typedef struct packed {
		logic [HUE_BITS-1:0]     hue;
		logic [CHANNEL_BITS-1:0] saturation;
		logic [CHANNEL_BITS-1:0] brightness;
		logic [CHANNEL_BITS-1:0] alpha_in;
	} hsv_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] alpha_out;
	} rgb_t;

	// Sixths of the hue circle, named by the colours at their two ends.
	typedef enum logic [2:0] {
		SEC_RED_YELLOW    = 3'd0,
		SEC_YELLOW_GREEN  = 3'd1,
		SEC_GREEN_CYAN    = 3'd2,
		SEC_CYAN_BLUE     = 3'd3,
		SEC_BLUE_MAGENTA  = 3'd4,
		SEC_MAGENTA_RED   = 3'd5
	} sector_t;

	// Load enables for the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage : hsvrgb_pkg
`default_nettype wire

// File: hdl/hsvrgb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_datapath
// Four-stage arithmetic of the HSV to RGB conversion: hue decode and V*S,
// the hue-weighted product, division by full scale, channel placement.
// ----------------------------------------------------------------------------
module hsvrgb_datapath (
	input  wire              clk,
	input  hsvrgb_pkg::pipe_en_t en,
	input  hsvrgb_pkg::hsv_t     hsv,
	output hsvrgb_pkg::rgb_t     rgb
);
	import hsvrgb_pkg::*;

	localparam int unsigned HB = HUE_BITS;
	localparam int unsigned CB = CHANNEL_BITS;

	typedef struct packed {
		logic [CB-1:0] qe;
		logic [CB:0]   r1;
	} fold_t;

	// First half of ceil(n / FULL): FULL = 2^CB - 1, so n >> CB is a
	// quotient estimate and the low part plus the estimate is the remainder,
	// which here always stays below twice FULL.
	function automatic fold_t fold_ceil(input logic [PROD_W-1:0] n);
		logic [PROD_W-1:0] adj;
		fold_t             f;
		adj  = n + PROD_W'(FULL - 1);
		f.qe = adj[PROD_W-1:CB];
		f.r1 = {1'b0, adj[CB-1:0]} + {1'b0, f.qe};
		return f;
	endfunction

	function automatic logic [CB-1:0] fold_finish(input fold_t f);
		return f.qe + CB'(f.r1 >= (CB+1)'(FULL));
	endfunction

	// ---------------- stage 1: hue decode, V*S ----------------
	logic [HB+2:0]   hue6;
	logic [HB+1:0]   hue3;
	logic [HB:0]     twice;
	logic [DIST_W-1:0] hue_gap;
	localparam logic [DIST_W-1:0] HUE_ONE = {1'b1, {HB{1'b0}}};

	always_comb begin
		hue6  = ({3'b000, hsv.hue} << 2) + ({3'b000, hsv.hue} << 1);
		hue3  = {2'b00, hsv.hue} + ({2'b00, hsv.hue} << 1);
		twice = {hue3[HB-1:0], 1'b0};
		if (twice[HB]) begin
			hue_gap = {1'b0, twice[HB-1:0]};
		end else begin
			hue_gap = HUE_ONE - twice;
		end
	end

	sector_t           sector_s1;
	logic [DIST_W-1:0] gap_s1;
	logic [PROD_W-1:0] p_s1;
	logic [CB-1:0]     v_s1;
	logic [CB-1:0]     a_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sector_s1 <= sector_t'(hue6[HB+2:HB]);
			gap_s1    <= hue_gap;
			p_s1      <= PROD_W'(hsv.saturation) * PROD_W'(hsv.brightness);
			v_s1      <= hsv.brightness;
			a_s1      <= hsv.alpha_in;
		end
	end

	// ---------------- stage 2: V*S weighted by hue distance ----------------
	sector_t           sector_s2;
	logic [Y_W-1:0]    y_s2;
	logic [PROD_W-1:0] p_s2;
	logic [CB-1:0]     v_s2;
	logic [CB-1:0]     a_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sector_s2 <= sector_s1;
			y_s2      <= Y_W'(p_s1) * Y_W'(gap_s1);
			p_s2      <= p_s1;
			v_s2      <= v_s1;
			a_s2      <= a_s1;
		end
	end

	// ---------------- stage 3: ceiling divisions ----------------
	// ceil(y / 2^HB) first; the ceiling of two nested ceilings equals the
	// ceiling of the whole quotient.
	logic [Y_W:0]      y_round;
	logic [PROD_W-1:0] ny;

	always_comb begin
		y_round = {1'b0, y_s2} + (Y_W+1)'((1 << HB) - 1);
		ny      = y_round[HB+PROD_W-1:HB];
	end

	sector_t       sector_s3;
	fold_t         fx_s3;
	fold_t         fz_s3;
	logic [CB-1:0] v_s3;
	logic [CB-1:0] a_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sector_s3 <= sector_s2;
			fx_s3     <= fold_ceil(ny);
			fz_s3     <= fold_ceil(p_s2);
			v_s3      <= v_s2;
			a_s3      <= a_s2;
		end
	end

	// ---------------- stage 4: channel levels and placement ----------------
	// The chroma channel equals V; the others are V less a rounded-up loss,
	// which never exceeds V, so no clamp is needed.
	logic [CB-1:0] lvl_c;
	logic [CB-1:0] lvl_x;
	logic [CB-1:0] lvl_z;
	rgb_t          rgb_d;

	always_comb begin
		lvl_c = v_s3;
		lvl_x = v_s3 - fold_finish(fx_s3);
		lvl_z = v_s3 - fold_finish(fz_s3);
		rgb_d.alpha_out = a_s3;
		case (sector_s3)
			SEC_RED_YELLOW: begin
				rgb_d.red = lvl_c; rgb_d.green = lvl_x; rgb_d.blue = lvl_z;
			end
			SEC_YELLOW_GREEN: begin
				rgb_d.red = lvl_x; rgb_d.green = lvl_c; rgb_d.blue = lvl_z;
			end
			SEC_GREEN_CYAN: begin
				rgb_d.red = lvl_z; rgb_d.green = lvl_c; rgb_d.blue = lvl_x;
			end
			SEC_CYAN_BLUE: begin
				rgb_d.red = lvl_z; rgb_d.green = lvl_x; rgb_d.blue = lvl_c;
			end
			SEC_BLUE_MAGENTA: begin
				rgb_d.red = lvl_x; rgb_d.green = lvl_z; rgb_d.blue = lvl_c;
			end
			default: begin
				rgb_d.red = lvl_c; rgb_d.green = lvl_z; rgb_d.blue = lvl_x;
			end
		endcase
	end

	rgb_t rgb_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			rgb_s4 <= rgb_d;
		end
	end

	assign rgb = rgb_s4;

endmodule : hsvrgb_datapath
`default_nettype wire

// File: hdl/hsv_to_rgb_pixel_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_core
// HSV to RGB pixel converter with valid/ready streams on both sides.
//
// One HSV pixel is taken on each beat of the hsv channel and one RGB pixel
// leaves on each beat of the rgb channel, in the same order. Hue is a
// fraction of a full turn; saturation, brightness and alpha are fractions of
// full scale. Alpha is carried through untouched.
// The datapath is four register stages. With rgb_ready held high, a pixel
// taken at a clock edge moves through s1 to s4 and is shown on rgb from s4,
// and a new pixel can be taken on every clock: one pixel per cycle sustained.
// Each stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up while the receiver stalls; hsv_ready
// falls only when all four stages are full and rgb_ready is low.
// Reset clears the valid bits only; the pipeline is empty afterwards and
// hsv_ready is high from the first cycle.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                hsv_valid,
	output logic               hsv_ready,
	input  hsvrgb_pkg::hsv_t   hsv,
	output logic               rgb_valid,
	input  wire                rgb_ready,
	output hsvrgb_pkg::rgb_t   rgb
);
	import hsvrgb_pkg::*;

	logic     valid_s1;
	logic     valid_s2;
	logic     valid_s3;
	logic     valid_s4;
	pipe_en_t adv;
	pipe_en_t en;

	always_comb begin
		adv.s4 = !valid_s4 || rgb_ready;
		adv.s3 = !valid_s3 || adv.s4;
		adv.s2 = !valid_s2 || adv.s3;
		adv.s1 = !valid_s1 || adv.s2;
		en.s1  = adv.s1 && hsv_valid;
		en.s2  = adv.s2 && valid_s1;
		en.s3  = adv.s3 && valid_s2;
		en.s4  = adv.s4 && valid_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv.s1) valid_s1 <= hsv_valid;
			if (adv.s2) valid_s2 <= valid_s1;
			if (adv.s3) valid_s3 <= valid_s2;
			if (adv.s4) valid_s4 <= valid_s3;
		end
	end

	hsvrgb_datapath u_datapath (
		.clk (clk),
		.en  (en),
		.hsv (hsv),
		.rgb (rgb)
	);

	assign hsv_ready = adv.s1;
	assign rgb_valid = valid_s4;

endmodule : hsv_to_rgb_pixel_core
`default_nettype wire

// File: hdl/hsvrgb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks on the HSV to RGB pixel core, bound to its top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              hsv_valid,
	input wire              hsv_ready,
	input hsvrgb_pkg::hsv_t hsv,
	input wire              rgb_valid,
	input wire              rgb_ready,
	input hsvrgb_pkg::rgb_t rgb
);
	import hsvrgb_pkg::*;

	// A stalled result beat keeps its data.
	a_rgb_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb))
		else $error("rgb beat changed while stalled");

	// Back-pressure reaches the input only when the output is stalled.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv_ready |-> rgb_valid && !rgb_ready)
		else $error("hsv_ready low without an output stall");

	// With the receiver ready, a taken pixel reaches the output in time.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready
		|=> rgb_valid)
		else $error("pixel did not reach the output in time");

	// That pixel keeps its alpha and no channel exceeds its brightness.
	a_values: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready ##1 1'b1
		|-> rgb.alpha_out == $past(hsv.alpha_in, 4)
			&& rgb.red <= $past(hsv.brightness, 4)
			&& rgb.green <= $past(hsv.brightness, 4)
			&& rgb.blue <= $past(hsv.brightness, 4))
		else $error("output pixel values inconsistent with input");

endmodule : hsvrgb_checker

bind hsv_to_rgb_pixel_core hsvrgb_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hsv_valid (hsv_valid),
	.hsv_ready (hsv_ready),
	.hsv       (hsv),
	.rgb_valid (rgb_valid),
	.rgb_ready (rgb_ready),
	.rgb       (rgb)
);
`default_nettype wire
